### hw/rtl/bmh_pkg.sv
package bmh_pkg;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One stored task record
  typedef struct packed {
    logic [15:0] task_id;
    logic [15:0] burst_len;
    logic [7:0]  prio_level;
  } task_rec_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] task_id;
    logic [15:0] burst_len;
    logic [7:0]  prio_level;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_task_id;
    logic [15:0] out_burst_len;
    logic [7:0]  out_prio_level;
    logic [6:0]  occupancy;
  } rsp_t;

endpackage

### hw/rtl/binary_min_heap_scheduler.sv
// Task scheduler queue kept as a binary min-heap on prio_level in one RAM.
//
// Request channel (req_valid/req_ready/req): each request is a push
// (mode = MODE_PUSH) carrying task_id, burst_len, prio_level, or a pop.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one response per
// request, in order, with status, the popped record (zero unless a pop
// succeeds) and the occupancy after the operation.
//
// One request is in work at a time. The RAM has one read and one write
// port with a registered read, so each heap level costs a read/compare pass.
// A push sifts up from the new leaf; a pop reads the root, then the last
// entry, and sifts it down. A full push or an empty pop goes straight to the
// response. The engine returns to idle as the response is registered, so the
// next request can be taken while that response waits.
// If the receiver stalls, the engine holds its finished result until the
// output register frees. Reset (synchronous, active high) empties the queue
// at once; the RAM needs no clearing since only entries below the count are used.
module binary_min_heap_scheduler #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bmh_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bmh_pkg::rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;           // child index width, holds 2*pos+2
  localparam int OW = (CW > 7) ? CW : 7;
  localparam int RW = $bits(bmh_pkg::task_rec_t);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DN_ROOT = 4'd3;
  localparam logic [3:0] S_DN_LAST = 4'd4;
  localparam logic [3:0] S_DN_CHK  = 4'd5;
  localparam logic [3:0] S_DN_L    = 4'd6;
  localparam logic [3:0] S_DN_R    = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0]           state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;        // current hole position
  bmh_pkg::task_rec_t   cur;        // record being sifted
  bmh_pkg::task_rec_t   lrec;       // left child captured during sift-down
  bmh_pkg::task_rec_t   pop_rec;    // record handed back by a pop
  logic [1:0]           status;

  logic                 we;
  logic [AW-1:0]        waddr;
  bmh_pkg::task_rec_t   wdata;
  logic [AW-1:0]        raddr;
  logic [RW-1:0]        rdata;
  bmh_pkg::task_rec_t   rd_rec;

  logic [AW-1:0]        parent_idx;
  logic [XW-1:0]        l_idx;
  logic [XW-1:0]        r_idx;
  logic [XW-1:0]        count_x;
  logic                 l_ok;
  logic                 r_ok;
  logic                 up_less;
  logic                 l_less;
  logic [7:0]           best_prio;
  logic                 r_less;
  logic                 out_free;
  logic [OW-1:0]        occ_wide;

  assign rd_rec     = rdata;
  assign parent_idx = (pos - AW'(1)) >> 1;
  assign l_idx      = {1'b0, pos, 1'b1};
  assign r_idx      = l_idx + XW'(1);
  assign count_x    = XW'(count);
  assign l_ok       = l_idx < count_x;
  assign r_ok       = r_idx < count_x;
  assign up_less    = cur.prio_level < rd_rec.prio_level;
  // left child wins on strict less-than, right must then beat the winner
  assign l_less     = lrec.prio_level < cur.prio_level;
  assign best_prio  = l_less ? lrec.prio_level : cur.prio_level;
  assign r_less     = r_ok && (rd_rec.prio_level < best_prio);
  assign out_free   = !rsp_valid || rsp_ready;
  assign occ_wide   = OW'(count);
  assign req_ready  = (state == S_IDLE);

  bmh_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    raddr = '0;
    case (state)
      S_IDLE: begin
        raddr = '0;                      // root, used by a pop
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent_idx;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_less) begin
          wdata = rd_rec;                // parent moves down into the hole
        end
      end
      S_DN_ROOT: begin
        raddr = count[AW-1:0];           // last entry, count already dropped
      end
      S_DN_CHK: begin
        if (l_ok) begin
          raddr = l_idx[AW-1:0];
        end else begin
          we = 1'b1;
        end
      end
      S_DN_L: begin
        raddr = r_idx[AW-1:0];
      end
      S_DN_R: begin
        we = 1'b1;
        if (r_less) begin
          wdata = rd_rec;
        end else if (l_less) begin
          wdata = lrec;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            pop_rec <= '0;
            if (req.mode == bmh_pkg::MODE_PUSH) begin
              if (count >= CW'(CAPACITY)) begin
                status <= bmh_pkg::STATUS_FULL;
                state  <= S_FIN;
              end else begin
                status         <= bmh_pkg::STATUS_OK;
                cur.task_id    <= req.task_id;
                cur.burst_len  <= req.burst_len;
                cur.prio_level <= req.prio_level;
                pos            <= count[AW-1:0];
                count          <= count + CW'(1);
                state          <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                status <= bmh_pkg::STATUS_EMPTY;
                state  <= S_FIN;
              end else begin
                status <= bmh_pkg::STATUS_OK;
                count  <= count - CW'(1);
                state  <= S_DN_ROOT;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_less) begin
            pos   <= parent_idx;
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_ROOT: begin
          pop_rec <= rd_rec;
          state   <= S_DN_LAST;
        end
        S_DN_LAST: begin
          cur   <= rd_rec;
          pos   <= '0;
          state <= S_DN_CHK;
        end
        S_DN_CHK: begin
          state <= l_ok ? S_DN_L : S_FIN;
        end
        S_DN_L: begin
          lrec  <= rd_rec;
          state <= S_DN_R;
        end
        S_DN_R: begin
          if (r_less) begin
            pos   <= r_idx[AW-1:0];
            state <= S_DN_CHK;
          end else if (l_less) begin
            pos   <= l_idx[AW-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register frees
          if (out_free) begin
            rsp.status         <= status;
            rsp.out_task_id    <= pop_rec.task_id;
            rsp.out_burst_len  <= pop_rec.burst_len;
            rsp.out_prio_level <= pop_rec.prio_level;
            rsp.occupancy      <= occ_wide[6:0];
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/bmh_ram.sv
module bmh_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
